// File: src/olpe_pkg.sv
package olpe_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int GROUP    = 8;
	localparam int NGROUPS  = CAPACITY / GROUP;
	localparam int GRP_W    = $clog2(GROUP);
	localparam int GSEL_W   = IDX_W - GRP_W;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 16;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int FPOS_W   = 6;
	localparam int ECNT_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_PREPEND   = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_TAKE_HEAD = 3'd3,
		CMD_TAKE_TAIL = 3'd4,
		CMD_REMOVE    = 3'd5,
		CMD_FIND      = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADIDX = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  k;
		logic [VAL_W-1:0]  value;
		logic [CNT_W-1:0]  cnt;
	} cell_ctrl_t;

endpackage

// File: src/olpe_cell.sv
module olpe_cell
	import olpe_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] index,
	input  cell_ctrl_t       ctrl,
	input  logic [VAL_W-1:0] left_data,
	input  logic [VAL_W-1:0] right_data,
	output logic [VAL_W-1:0] data,
	output logic             match
);

	logic [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (index > ctrl.k) begin
					entry_q <= left_data;
				end else if (index == ctrl.k) begin
					entry_q <= ctrl.value;
				end
			end
			CELL_REMOVE: begin
				if (index >= ctrl.k) begin
					entry_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data  = entry_q;
	assign match = (CNT_W'(index) < ctrl.cnt) && (entry_q == ctrl.value);

endmodule

// File: src/olpe_first_match.sv
module olpe_first_match
	import olpe_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [CAPACITY-1:0] match_s1,
	output logic                hit,
	output logic [IDX_W-1:0]    hit_index
);

	logic [NGROUPS-1:0]  grp_any;
	logic [GRP_W-1:0]    grp_idx [NGROUPS];
	logic [NGROUPS-1:0]  grp_any_s2;
	logic [GRP_W-1:0]    grp_idx_s2 [NGROUPS];

	// first set bit inside each group
	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			grp_any[g] = |match_s1[g*GROUP +: GROUP];
			grp_idx[g] = '0;
			for (int b = GROUP - 1; b >= 0; b--) begin
				if (match_s1[g*GROUP + b]) begin
					grp_idx[g] = GRP_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NGROUPS; g++) begin
				grp_any_s2[g] <= grp_any[g];
				grp_idx_s2[g] <= grp_idx[g];
			end
		end
	end

	// first group with a hit
	always_comb begin
		logic [GSEL_W-1:0] sel;
		sel = '0;
		for (int g = NGROUPS - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				sel = GSEL_W'(g);
			end
		end
		hit       = |grp_any_s2;
		hit_index = {sel, grp_idx_s2[sel]};
	end

endmodule

// File: src/ordered_list_positional_engine.sv
// ordered list of up to 64 signed 32-bit values, one command per transfer
//
// command channel: command, position, value with cmd_valid / cmd_stall
// result channel: status, found, found_position, entry_count with
// res_valid / res_stall; every command gives exactly one result
//
// the list lives in a row of cells; insert and remove shift each cell from
// the target position on toward or from its neighbor in the cycle the
// command is taken, and find compares all cells at once, so a new command
// is taken every cycle while cmd_stall is low
// three register stages: the cell update and compare, a two-level registered
// first-match search over groups of eight cells, then the result register
//
// when res_stall is high with a result waiting, the whole pipeline holds
// and cmd_stall rises; nothing is lost
// reset empties the list (count to zero) and clears all valid flags;
// cell contents are not cleared since entries past the count are never read

module ordered_list_positional_engine
	import olpe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic signed [POS_W-1:0] position,
	input  logic signed [VAL_W-1:0] value,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [STAT_W-1:0] status,
	output logic              found,
	output logic [FPOS_W-1:0] found_position,
	output logic [ECNT_W-1:0] entry_count
);

	logic             adv;
	logic             accept;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] cnt_m1;
	cell_op_t         op;
	logic [IDX_W-1:0] k;
	status_t          status_n;
	logic             full;
	logic             pos_neg;
	logic             pos_ge;
	cell_ctrl_t       ctrl;

	logic [VAL_W-1:0]    cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	logic                v_s1, v_s2;
	logic                find_s1, find_s2;
	status_t             status_s1, status_s2;
	logic [CNT_W-1:0]    cnt_s1, cnt_s2;
	logic [CAPACITY-1:0] match_s1;

	logic             hit;
	logic [IDX_W-1:0] hit_index;

	logic              res_valid_q;
	status_t           status_q;
	logic              found_q;
	logic [IDX_W-1:0]  fpos_q;
	logic [CNT_W-1:0]  cnt_out_q;

	assign adv       = !res_valid_q || !res_stall;
	assign accept    = cmd_valid && adv;
	assign cmd_stall = !adv;

	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign pos_neg = position[POS_W-1];
	assign pos_ge  = !pos_neg && (position[POS_W-2:0] >= (POS_W-1)'(cnt_q));
	assign cnt_m1  = cnt_q - CNT_W'(1);

	always_comb begin
		op       = CELL_HOLD;
		k        = '0;
		status_n = ST_OK;
		cnt_n    = cnt_q;
		unique case (cmd_t'(command)) inside
			CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					op    = CELL_INSERT;
					cnt_n = cnt_q + CNT_W'(1);
					if (cmd_t'(command) == CMD_APPEND) begin
						k = cnt_q[IDX_W-1:0];
					end else if (cmd_t'(command) == CMD_PREPEND) begin
						k = '0;
					end else if (pos_neg || position == '0) begin
						k = '0;
					end else if (pos_ge) begin
						k = cnt_q[IDX_W-1:0];
					end else begin
						k = position[IDX_W-1:0];
					end
				end
			end
			CMD_TAKE_HEAD, CMD_TAKE_TAIL: begin
				if (cnt_q == '0) begin
					status_n = ST_EMPTY;
				end else begin
					op    = CELL_REMOVE;
					cnt_n = cnt_m1;
					k     = (cmd_t'(command) == CMD_TAKE_TAIL) ? cnt_m1[IDX_W-1:0] : '0;
				end
			end
			CMD_REMOVE: begin
				if (pos_neg || pos_ge) begin
					status_n = ST_BADIDX;
				end else begin
					op    = CELL_REMOVE;
					cnt_n = cnt_m1;
					k     = position[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctrl.op    = accept ? op : CELL_HOLD;
		ctrl.k     = k;
		ctrl.value = value;
		ctrl.cnt   = cnt_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = value;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		olpe_cell u_cell (
			.clk        (clk),
			.index      (IDX_W'(i)),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_n;
			end
			if (adv) begin
				v_s1        <= cmd_valid;
				v_s2        <= v_s1;
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			find_s1   <= (cmd_t'(command) == CMD_FIND);
			status_s1 <= status_n;
			cnt_s1    <= cnt_n;
			match_s1  <= cell_match;
			find_s2   <= find_s1;
			status_s2 <= status_s1;
			cnt_s2    <= cnt_s1;
			status_q  <= status_s2;
			found_q   <= find_s2 && hit;
			fpos_q    <= (find_s2 && hit) ? hit_index : '0;
			cnt_out_q <= cnt_s2;
		end
	end

	olpe_first_match u_first_match (
		.clk       (clk),
		.en        (adv),
		.match_s1  (match_s1),
		.hit       (hit),
		.hit_index (hit_index)
	);

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign found          = found_q;
	assign found_position = FPOS_W'(fpos_q);
	assign entry_count    = ECNT_W'(cnt_out_q);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (command == CMD_APPEND || command == CMD_PREPEND
			|| command == CMD_INSERT) |=> cnt_q == CNT_W'(CAPACITY))
		else $error("insert into full list changed the count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found |-> status == ST_OK && found_position < entry_count)
		else $error("find hit outside the list");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(entry_count) && $stable(status))
		else $error("stalled result changed");

endmodule

// File: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import olpe_pkg::*;

	localparam int N_RANDOM   = 900;
	localparam int HOLD_LEN   = 400;
	localparam int CYCLE_CAP  = 300000;
	localparam int PRINT_CAP  = 100;
	localparam int TAIL_WAIT  = 8;

	typedef struct {
		cmd_t                    cmd;
		logic signed [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		int                      gap;
		bit                      drain;
	} list_cmd_t;

	typedef struct {
		status_t             status;
		logic                found;
		logic [FPOS_W-1:0]   fpos;
		logic [ECNT_W-1:0]   cnt;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic [CMD_W-1:0]        command = CMD_APPEND;
	logic signed [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [STAT_W-1:0]       status;
	logic                    found;
	logic [FPOS_W-1:0]       found_position;
	logic [ECNT_W-1:0]       entry_count;

	ordered_list_positional_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command        (command),
		.position       (position),
		.value          (value),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.found          (found),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow list and predicted results
	logic signed [VAL_W-1:0] shadow_list[$];
	list_result_t            result_q[$];
	list_cmd_t               pending[$];

	int errors = 0;
	int n_sent = 0;
	int n_recv = 0;
	int gen_count = 0;
	int n_full = 0, n_empty = 0, n_badidx = 0, n_hits = 0, peak = 0;

	function automatic list_result_t apply_command(input list_cmd_t c);
		list_result_t r;
		int           i;
		r.status = ST_OK;
		r.found  = 1'b0;
		r.fpos   = '0;
		case (c.cmd)
			CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
				if (shadow_list.size() >= CAPACITY)
					r.status = ST_FULL;
				else if (c.cmd == CMD_APPEND)
					shadow_list.insert(shadow_list.size(), c.val);
				else if (c.cmd == CMD_PREPEND || c.pos <= 0)
					shadow_list.insert(0, c.val);
				else if (int'(c.pos) >= shadow_list.size())
					shadow_list.insert(shadow_list.size(), c.val);
				else
					shadow_list.insert(int'(c.pos), c.val);
			end
			CMD_TAKE_HEAD: begin
				if (shadow_list.size() == 0)
					r.status = ST_EMPTY;
				else
					shadow_list.delete(0);
			end
			CMD_TAKE_TAIL: begin
				if (shadow_list.size() == 0)
					r.status = ST_EMPTY;
				else
					shadow_list.delete(shadow_list.size() - 1);
			end
			CMD_REMOVE: begin
				if (c.pos < 0 || int'(c.pos) >= shadow_list.size())
					r.status = ST_BADIDX;
				else
					shadow_list.delete(int'(c.pos));
			end
			CMD_FIND: begin
				for (i = 0; i < shadow_list.size(); i++) begin
					if (!r.found && shadow_list[i] == c.val) begin
						r.found = 1'b1;
						r.fpos  = FPOS_W'(i);
					end
				end
			end
			default: ;
		endcase
		r.cnt = ECNT_W'(shadow_list.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int idx, input longint got,
			input longint want);
		if (errors < PRINT_CAP)
			$display("mismatch %s at result %0d: got %0h want %0h", what, idx, got, want);
		errors++;
	endtask

	// count evolution does not depend on values, so the generator can track it
	task automatic queue_item(input cmd_t c, input logic signed [POS_W-1:0] p,
			input logic signed [VAL_W-1:0] v, input int gap, input bit drain);
		list_cmd_t it;
		it.cmd   = c;
		it.pos   = p;
		it.val   = v;
		it.gap   = gap;
		it.drain = drain;
		pending = {pending, it};
		case (c)
			CMD_APPEND, CMD_PREPEND, CMD_INSERT:
				if (gen_count < CAPACITY) gen_count++;
			CMD_TAKE_HEAD, CMD_TAKE_TAIL:
				if (gen_count > 0) gen_count--;
			CMD_REMOVE:
				if (p >= 0 && int'(p) < gen_count) gen_count--;
			default: ;
		endcase
	endtask

	// driver
	list_cmd_t drv_cur;
	int        drv_wait = 0;
	int        sent_now;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			command   <= CMD_APPEND;
			position  <= '0;
			value     <= '0;
			drv_wait  <= 0;
			n_sent    <= 0;
		end else begin
			sent_now = n_sent;
			if (cmd_valid && !cmd_stall) begin
				result_q = {result_q, apply_command(drv_cur)};
				sent_now = n_sent + 1;
				n_sent <= sent_now;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (pending.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (drv_wait < pending[0].gap) begin
					cmd_valid <= 1'b0;
					drv_wait  <= drv_wait + 1;
				end else if (pending[0].drain && n_recv != sent_now) begin
					cmd_valid <= 1'b0;
				end else begin
					drv_cur   <= pending[0];
					command   <= pending[0].cmd;
					position  <= pending[0].pos;
					value     <= pending[0].val;
					cmd_valid <= 1'b1;
					drv_wait  <= 0;
					pending.delete(0);
				end
			end
		end
	end

	// long receiver hold-off so the pipeline fills and backs up
	int hold_left = 0;
	int hold_idx = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_idx  <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_idx < 2 && n_sent >= (hold_idx == 0 ? 250 : 650)) begin
			hold_left <= HOLD_LEN;
			hold_idx  <= hold_idx + 1;
		end
	end

	// monitor
	list_result_t mon_want;
	int           rx_left = 0;
	int           rx_pick;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_left   <= 0;
			n_recv    <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", n_recv, entry_count, 0);
				end else begin
					mon_want = result_q[0];
					result_q.delete(0);
					if (status !== mon_want.status)
						report_mismatch("status", n_recv, status, mon_want.status);
					if (found !== mon_want.found)
						report_mismatch("found", n_recv, found, mon_want.found);
					if (found_position !== mon_want.fpos)
						report_mismatch("found_position", n_recv, found_position,
							mon_want.fpos);
					if (entry_count !== mon_want.cnt)
						report_mismatch("entry_count", n_recv, entry_count, mon_want.cnt);
					case (mon_want.status)
						ST_FULL:   n_full++;
						ST_EMPTY:  n_empty++;
						ST_BADIDX: n_badidx++;
						default:   ;
					endcase
					if (mon_want.found) n_hits++;
					if (int'(mon_want.cnt) > peak) peak = mon_want.cnt;
				end
				n_recv <= n_recv + 1;
				rx_pick = ((n_recv / 50) % 3 == 0) ? 0 : $urandom_range(0, 16);
			end else begin
				rx_pick = (rx_left > 0) ? rx_left - 1 : 0;
			end
			rx_left   <= rx_pick;
			res_stall <= (hold_left != 0) || (rx_pick != 0);
		end
	end

	// run limit
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic signed [VAL_W-1:0] pool [8];
		int                      k, r, mode, add_pct, find_pct, gap;
		cmd_t                    c;
		logic signed [POS_W-1:0] p;
		logic signed [VAL_W-1:0] v;

		pool[0] = 32'sh0000_0000;
		pool[1] = -32'sd1;
		pool[2] = 32'sh7fff_ffff;
		pool[3] = 32'sh8000_0000;
		for (k = 4; k < 8; k++)
			pool[k] = $urandom();

		// empty list corners, clamped inserts, find hits and misses, bad indexes
		queue_item(CMD_TAKE_HEAD, 0, 0, 0, 0);
		queue_item(CMD_TAKE_TAIL, 0, 0, 0, 0);
		queue_item(CMD_REMOVE, 0, 0, 0, 0);
		queue_item(CMD_FIND, 0, 0, 0, 0);
		queue_item(CMD_INSERT, 16'sh8000, 0, 0, 0);
		queue_item(CMD_APPEND, 0, 32'sh7fff_ffff, 0, 0);
		queue_item(CMD_PREPEND, 0, 32'sh8000_0000, 0, 0);
		queue_item(CMD_INSERT, 16'sh7fff, -32'sd1, 0, 0);
		queue_item(CMD_INSERT, 1, 32'sd12345, 0, 0);
		queue_item(CMD_INSERT, 0, 32'sd5, 0, 0);
		queue_item(CMD_FIND, 0, 32'sh7fff_ffff, 0, 0);
		queue_item(CMD_FIND, 0, -32'sd1, 0, 0);
		queue_item(CMD_FIND, 0, 32'sd42, 0, 0);
		queue_item(CMD_REMOVE, -16'sd1, 0, 0, 0);
		queue_item(CMD_REMOVE, 16'sh7fff, 0, 0, 0);
		queue_item(CMD_REMOVE, POS_W'(gen_count), 0, 0, 0);
		queue_item(CMD_REMOVE, 2, 0, 0, 0);
		queue_item(CMD_REMOVE, 0, 0, 0, 0);
		queue_item(CMD_TAKE_HEAD, 0, 0, 0, 0);
		queue_item(CMD_TAKE_TAIL, 0, 0, 0, 0);
		queue_item(CMD_FIND, 0, 32'sh8000_0000, 0, 0);
		queue_item(CMD_APPEND, 16'sh7fff, 0, 0, 0);
		queue_item(CMD_APPEND, 16'sh8000, 0, 0, 0);
		queue_item(CMD_FIND, 0, 0, 0, 0);
		queue_item(CMD_REMOVE, 16'sh8000, 32'shffff_ffff, 0, 0);

		// phases: grow toward full, mixed, shrink toward empty
		for (k = 0; k < N_RANDOM; k++) begin
			mode = (k / 150) % 3;
			add_pct  = (mode == 0) ? 85 : (mode == 1) ? 50 : 10;
			find_pct = (mode == 0) ? 5 : (mode == 1) ? 17 : 30;
			r = $urandom_range(0, 99);
			if (r < add_pct) begin
				case ($urandom_range(0, 2))
					0:       c = CMD_APPEND;
					1:       c = CMD_PREPEND;
					default: c = CMD_INSERT;
				endcase
			end else if (r < add_pct + find_pct) begin
				c = CMD_FIND;
			end else begin
				case ($urandom_range(0, 2))
					0:       c = CMD_TAKE_HEAD;
					1:       c = CMD_TAKE_TAIL;
					default: c = CMD_REMOVE;
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				p = POS_W'($urandom());
			else
				p = POS_W'($urandom_range(0, gen_count));
			if ($urandom_range(0, 9) < 6)
				v = pool[$urandom_range(0, 7)];
			else
				v = $urandom();
			gap = ((k / 60) % 3 == 0) ? 0 : $urandom_range(0, 16);
			queue_item(c, p, v, gap, (k == 0 || k == 450));
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending.size() != 0 || cmd_valid) @(posedge clk);
		while (n_recv != n_sent) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (result_q.size() != 0)
			report_mismatch("missing results", n_recv, 0, result_q.size());

		$display("%0d commands and results; %0d full, %0d empty, %0d bad index statuses",
			n_sent, n_full, n_empty, n_badidx);
		$display("%0d find hits, peak fill %0d of %0d, %0d mismatches",
			n_hits, peak, CAPACITY, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
